FILE: rtl/tcw_pkg.sv
package tcw_pkg;

    // default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // field widths
    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;
    localparam int LOC_W  = 11;
    localparam int CELL_W = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // cell constants: every cell carries the grey attribute for its whole life
    localparam logic [CHAR_W-1:0] ATTR_BYTE    = 8'h07;
    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_SCROLL,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_PUT,
        WR_SCROLL,
        WR_BLANK
    } t_wr_sel;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_ACCEPT,
        RD_AHEAD
    } t_rd_sel;

    typedef struct packed {
        logic    accept;
        t_wr_sel wr_sel;
        t_rd_sel rd_sel;
        logic    load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic sweep_last;
        logic put_scrolls;
        logic out_free;
    } t_dp_status;

endpackage

FILE: rtl/tcw_ctrl.sv
module tcw_ctrl import tcw_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_command,
    input  t_dp_status       i_status,
    output logic             o_in_ready,
    output t_ctrl_cmd        o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_in_ready      = 1'b0;
        o_cmd.accept    = 1'b0;
        o_cmd.wr_sel    = WR_NONE;
        o_cmd.rd_sel    = RD_NONE;
        o_cmd.load_out  = 1'b0;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.wr_sel = WR_BLANK;
                if (i_status.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    o_cmd.rd_sel = RD_ACCEPT;
                    priority if (i_command == CMD_PUT) begin
                        o_cmd.wr_sel = WR_PUT;
                        n_state = i_status.put_scrolls ? ST_SCROLL : ST_DONE;
                    end else if (i_command == CMD_CLEAR) begin
                        n_state = ST_CLEAR;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_CLEAR: begin
                o_cmd.wr_sel = WR_BLANK;
                if (i_status.sweep_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_SCROLL: begin
                o_cmd.wr_sel = WR_SCROLL;
                o_cmd.rd_sel = RD_AHEAD;
                if (i_status.sweep_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

endmodule

FILE: rtl/tcw_datapath.sv
module tcw_datapath import tcw_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl_cmd         i_cmd,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [IDX_W-1:0]  i_cell_index,
    input  logic              i_out_ready,
    output t_dp_status        o_status,
    output logic              o_out_valid,
    output logic [LOC_W-1:0]  o_cursor_location,
    output logic [CELL_W-1:0] o_cell_value,
    output logic              o_scrolled
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int AHEAD_W    = ADDR_W + 1;
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int KEEP_END   = CELL_COUNT - COLUMNS;

    // character store, attribute is constant
    logic [CHAR_W-1:0] r_mem [CELL_COUNT];
    logic [CHAR_W-1:0] r_rd_data;

    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [ADDR_W-1:0] r_base;
    logic [ADDR_W-1:0] r_sweep;
    logic              r_rd_ok;
    logic              r_scr;

    logic              r_out_valid;
    logic [LOC_W-1:0]  r_out_loc;
    logic [CELL_W-1:0] r_out_cell;
    logic              r_out_scr;

    logic               newline;
    logic               row_adv;
    logic               put_scrolls;
    logic               idx_in_range;
    logic               is_put;
    logic               sweep_last;
    logic [AHEAD_W-1:0] ahead;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [CHAR_W-1:0]  wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  cursor_addr;

    assign newline      = (i_char_code == NEWLINE_CHAR);
    assign row_adv      = newline || (r_col == COL_W'(COLUMNS - 1));
    assign put_scrolls  = row_adv && (r_row == ROW_W'(ROWS - 1));
    assign idx_in_range = (32'(i_cell_index) < 32'(CELL_COUNT));
    assign is_put       = i_cmd.accept && (i_command == CMD_PUT);
    assign sweep_last   = (r_sweep == ADDR_W'(CELL_COUNT - 1));
    assign ahead        = AHEAD_W'(r_sweep) + AHEAD_W'(COLUMNS + 1);
    assign cursor_addr  = r_base + ADDR_W'(r_col);

    assign o_status.sweep_last  = sweep_last;
    assign o_status.put_scrolls = put_scrolls;
    assign o_status.out_free    = !r_out_valid || i_out_ready;

    // write port select
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_sweep;
        wr_data = BLANK_CHAR;
        unique case (i_cmd.wr_sel)
            WR_PUT: begin
                wr_en   = !newline;
                wr_addr = cursor_addr;
                wr_data = i_char_code;
            end
            WR_SCROLL: begin
                wr_en   = 1'b1;
                wr_data = (r_sweep < ADDR_W'(KEEP_END)) ? r_rd_data : BLANK_CHAR;
            end
            WR_BLANK: begin
                wr_en = 1'b1;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // read port select; a put prefetches the first row to move in case it scrolls
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        unique case (i_cmd.rd_sel)
            RD_ACCEPT: begin
                rd_en = 1'b1;
                if (i_command == CMD_READ) begin
                    rd_addr = idx_in_range ? ADDR_W'(i_cell_index) : '0;
                end else begin
                    rd_addr = ADDR_W'(COLUMNS);
                end
            end
            RD_AHEAD: begin
                rd_en   = 1'b1;
                rd_addr = (ahead < AHEAD_W'(CELL_COUNT)) ? ADDR_W'(ahead) : '0;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // cursor and sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_base  <= '0;
            r_sweep <= '0;
            r_rd_ok <= 1'b0;
            r_scr   <= 1'b0;
        end else begin
            if (i_cmd.wr_sel == WR_SCROLL || i_cmd.wr_sel == WR_BLANK) begin
                r_sweep <= sweep_last ? '0 : r_sweep + 1'b1;
            end
            if (i_cmd.accept) begin
                r_rd_ok <= (i_command == CMD_READ) && idx_in_range;
                r_scr   <= (i_command == CMD_PUT) && put_scrolls;
                if (i_command == CMD_CLEAR) begin
                    r_col  <= '0;
                    r_row  <= '0;
                    r_base <= '0;
                end
            end
            if (is_put) begin
                if (row_adv) begin
                    r_col <= '0;
                    if (put_scrolls) begin
                        r_base <= ADDR_W'(KEEP_END);
                    end else begin
                        r_row  <= r_row + 1'b1;
                        r_base <= r_base + ADDR_W'(COLUMNS);
                    end
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_loc  <= LOC_W'(cursor_addr);
            r_out_cell <= r_rd_ok ? {ATTR_BYTE, r_rd_data} : '0;
            r_out_scr  <= r_scr;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_cursor_location = r_out_loc;
    assign o_cell_value      = r_out_cell;
    assign o_scrolled        = r_out_scr;

`ifndef SYNTH
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < COLUMNS)
        else $error("cursor column out of range");

    a_base_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_base) == 32'(r_row) * COLUMNS)
        else $error("row base does not match cursor row");

    a_scroll_loc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out && r_scr |=> o_cursor_location == LOC_W'(KEEP_END))
        else $error("scroll did not leave cursor at last row start");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> !r_out_valid || i_out_ready)
        else $error("result loaded over an untaken result");
`endif

endmodule

FILE: rtl/text_console_writer.sv
// channel   direction  handshake                 payload
// in        to block   i_in_valid / o_in_ready   i_command, i_char_code, i_cell_index
// out       from block o_out_valid / i_out_ready o_cursor_location, o_cell_value, o_scrolled
//
// put, read and unused commands: transfer in, then result into the output reg once it is free
// clear and a put that scrolls sweep all COLUMNS*ROWS cells, one cell per cycle
// through the single write port of the character store, then load the result
// after reset a clearing pass over all COLUMNS*ROWS cells fills the store, o_in_ready low
// a result waiting on i_out_ready stalls only the next result load, not the transfer in
module text_console_writer import tcw_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [IDX_W-1:0]  i_cell_index,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [LOC_W-1:0]  o_cursor_location,
    output logic [CELL_W-1:0] o_cell_value,
    output logic              o_scrolled
);

    // commands from the sequencer, status back from the datapath
    t_ctrl_cmd  cmd;
    t_dp_status status;

    // sequencer: reset fill, accept, clear and scroll sweeps, result load
    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // datapath: character store, cursor, sweep counter, output register
    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_command         (i_command),
        .i_char_code       (i_char_code),
        .i_cell_index      (i_cell_index),
        .i_out_ready       (i_out_ready),
        .o_status          (status),
        .o_out_valid       (o_out_valid),
        .o_cursor_location (o_cursor_location),
        .o_cell_value      (o_cell_value),
        .o_scrolled        (o_scrolled)
    );

endmodule
